/* rtl/core/stbs_pkg.sv */
package stbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int POSITION_W  = 8;
   localparam int PORT_VALUE_W = 32;
   localparam int COUNT_W     = 9;
   localparam int INDEX_OUT_W = 8;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_SEARCH = 1'b1
   } action_type;

   typedef struct packed {
      logic load;        // start a search: set range and target
      logic write;       // store an entry
      logic probe;       // register midpoint, read the table there
      logic step;        // narrow the range after a compare
      logic latch_hit;   // record a match at the midpoint
      logic latch_miss;  // record no match
      logic publish;     // move the recorded result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic less;
   } dp_status_type;

endpackage

/* rtl/core/stbs_chan_if.sv */
interface stbs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [stbs_pkg::POSITION_W-1:0]       position;
   logic signed [stbs_pkg::PORT_VALUE_W-1:0] value;

   modport source (output valid, output action, output position, output value, input ready);
   modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface stbs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  found;
   logic [stbs_pkg::INDEX_OUT_W-1:0]      found_index;

   modport source (output valid, output found, output found_index, input ready);
   modport sink   (input valid, input found, input found_index, output ready);
endinterface

interface stbs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [stbs_pkg::COUNT_W-1:0]          data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/stbs_datapath.sv */
module stbs_datapath #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  stbs_pkg::dp_cmd_type                     cmd,
   output stbs_pkg::dp_status_type                  status,
   input  logic [stbs_pkg::POSITION_W-1:0]          req_position,
   input  logic signed [stbs_pkg::PORT_VALUE_W-1:0] req_value,
   input  logic                                     csr_write,
   input  logic [stbs_pkg::COUNT_W-1:0]             csr_data,
   output logic                                     rsp_found,
   output logic [stbs_pkg::INDEX_OUT_W-1:0]         rsp_found_index
);
   import stbs_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int RANGE_W = ADDR_W + 2;

   logic [VALUE_WIDTH-1:0]     table_mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0]     rd_data_ff;
   logic [VALUE_WIDTH-1:0]     target_ff;
   logic [VALUE_WIDTH-1:0]     value_narrow;
   logic [COUNT_W-1:0]         entries_ff;
   logic signed [RANGE_W-1:0]  low_ff, low_in;
   logic signed [RANGE_W-1:0]  high_ff, high_in;
   logic signed [RANGE_W-1:0]  mid_ff;
   logic signed [RANGE_W-1:0]  mid_sum;
   logic signed [RANGE_W-1:0]  count_clamped;
   logic                       found_ff;
   logic [INDEX_OUT_W-1:0]     index_ff;
   logic                       rsp_found_ff;
   logic [INDEX_OUT_W-1:0]     rsp_index_ff;

   // only the low bits of the port value count; wider tables zero-extend
   assign value_narrow = VALUE_WIDTH'($unsigned(req_value));

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_write) begin
         entries_ff <= csr_data;
      end
   end

   always_comb begin
      if (32'(entries_ff) > 32'(TABLE_DEPTH)) begin
         count_clamped = RANGE_W'(TABLE_DEPTH);
      end else begin
         count_clamped = RANGE_W'(entries_ff);
      end
   end

   // range is never empty when probing, so both bounds are non-negative here
   assign mid_sum = (low_ff + high_ff) >>> 1;

   always_ff @(posedge clock) begin
      if (cmd.write && (32'(req_position) < 32'(TABLE_DEPTH))) begin
         table_mem[ADDR_W'(req_position)] <= value_narrow;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe) begin
         rd_data_ff <= table_mem[mid_sum[ADDR_W-1:0]];
         mid_ff     <= mid_sum;
      end
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.load) begin
         low_in  = '0;
         high_in = count_clamped - RANGE_W'(1);
      end else if (cmd.step) begin
         if (status.less) begin
            low_in = mid_ff + RANGE_W'(1);
         end else begin
            high_in = mid_ff - RANGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (cmd.load) begin
         target_ff <= value_narrow;
      end
      if (cmd.latch_hit) begin
         found_ff <= 1'b1;
         index_ff <= INDEX_OUT_W'($unsigned(mid_ff));
      end else if (cmd.latch_miss) begin
         found_ff <= 1'b0;
         index_ff <= '0;
      end
      if (cmd.publish) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= index_ff;
      end
   end

   assign status.empty = low_ff > high_ff;
   assign status.hit   = rd_data_ff == target_ff;
   assign status.less  = $signed(rd_data_ff) < $signed(target_ff);

   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;

   a_probe_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |=> (mid_ff >= 0) && (mid_ff < RANGE_W'(TABLE_DEPTH)))
      else $error("probe outside the table");

   a_step_narrows: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (low_ff > $past(low_ff)) || (high_ff < $past(high_ff)))
      else $error("search range did not shrink");

   a_hit_index: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_hit |=> found_ff && (index_ff == INDEX_OUT_W'($unsigned($past(mid_ff)))))
      else $error("recorded index differs from probed midpoint");

endmodule

/* rtl/core/stbs_controller.sv */
module stbs_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output stbs_pkg::dp_cmd_type     cmd,
   input  stbs_pkg::dp_status_type  status
);
   import stbs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CHECK   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;

   assign req_ready = state_ff == ST_IDLE;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_action == ACT_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (status.empty) begin
               cmd.latch_miss = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.hit) begin
               cmd.latch_hit = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // wait here while the output register still holds an untaken result
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over an untaken one");

   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_SEARCH)) |=> (state_ff == ST_CHECK))
      else $error("search transfer did not start a search");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish state");

endmodule

/* rtl/core/sorted_table_binary_search_top.sv */
// Sorted table binary search.
// req_chan: valid/ready transfer of {action, position, value}. A write item
//   (action 0) stores value at position and gives no result;
//   positions beyond the table are dropped. A search item (action 1) looks
//   for value among entries 0 .. entries_in_use-1, compared as signed words.
// rsp_chan: one {found, found_index} transfer per search; index is 0 on miss.
// csr_chan: writes entries_in_use (values above the table depth count as the
//   depth). Always ready; write it only while no search is in flight.
// Search: each probe is a registered table read, then a compare, on the
//   single read port; p <= ceil(log2(n+1)) probes, 9 for 256 entries. A
//   miss ends with one more range check than a hit. The result then moves
//   into the output register, and the next item is taken after that.
// One search is worked at a time. A waiting result sits in the output
//   register; the next search runs meanwhile and holds at its end while
//   rsp_chan is stalled. Reset clears entries_in_use and the handshake
//   state; table contents are undefined until written.
module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   stbs_req_if.sink   req_chan,
   stbs_rsp_if.source rsp_chan,
   stbs_csr_if.sink   csr_chan
);
   import stbs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   stbs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_position    (req_chan.position),
      .req_value       (req_chan.value),
      .csr_write       (csr_write),
      .csr_data        (csr_chan.data),
      .rsp_found       (rsp_chan.found),
      .rsp_found_index (rsp_chan.found_index)
   );

endmodule
